@@ hdl/mwta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwta_pkg: shared constants and types for the trailing average block
// Sample format, window lengths, sum widths and the reciprocals that the
// constant dividers use.
// ----------------------------------------------------------------------------
package mwta_pkg;

  // Sample width (signed, 8 fraction bits) and depth of the history line
  localparam int SAMPLE_BITS    = 24;
  localparam int LONGEST_WINDOW = 120;
  localparam int WIN_COUNT      = 6;

  // Window lengths, shortest first; bit k of the valid mask follows entry k
  localparam int WIN_LEN [WIN_COUNT] = '{3, 5, 10, 30, 60, 120};

  // Exact window sum: |sum| <= LONGEST_WINDOW * 2^(SAMPLE_BITS-1)
  localparam int SUM_W  = SAMPLE_BITS + $clog2(LONGEST_WINDOW);
  localparam int MAG_W  = SUM_W;
  localparam int SEEN_W = $clog2(LONGEST_WINDOW + 1);

  // Reciprocal divide: q = (n * ceil(2^(MAG_W+l) / d)) >> (MAG_W+l), l = clog2(d)
  localparam int RECIP_W = MAG_W + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int SHIFT_W = $clog2(PROD_W);

  localparam int DIV_SHIFT [WIN_COUNT] = '{
    $clog2(3), $clog2(5), $clog2(10), $clog2(30), $clog2(60), $clog2(120)
  };

  localparam logic [RECIP_W-1:0] RECIP [WIN_COUNT] = '{
    RECIP_W'(((64'd1 << (MAG_W + $clog2(3)))   + 64'd2)   / 64'd3),
    RECIP_W'(((64'd1 << (MAG_W + $clog2(5)))   + 64'd4)   / 64'd5),
    RECIP_W'(((64'd1 << (MAG_W + $clog2(10)))  + 64'd9)   / 64'd10),
    RECIP_W'(((64'd1 << (MAG_W + $clog2(30)))  + 64'd29)  / 64'd30),
    RECIP_W'(((64'd1 << (MAG_W + $clog2(60)))  + 64'd59)  / 64'd60),
    RECIP_W'(((64'd1 << (MAG_W + $clog2(120))) + 64'd119) / 64'd120)
  };

  // Stage advance strobes handed to each divider lane
  typedef struct packed {
    logic mul;  // load the product register
    logic fin;  // load the result register
  } mwta_adv_t;

endpackage

@@ hdl/mwta_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwta_cell: one tap of the sample history line
// Holds one sample and takes its neighbor's sample on every accepted word.
// ----------------------------------------------------------------------------
module mwta_cell
  import mwta_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          shift_i,
  input  logic signed [SAMPLE_BITS-1:0] d_i,
  output logic signed [SAMPLE_BITS-1:0] q_o
);

  logic signed [SAMPLE_BITS-1:0] smp_q;

  // Shift register tap; contents past the fill count are never used
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      smp_q <= d_i;
    end
  end

  assign q_o = smp_q;

endmodule

@@ hdl/mwta_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwta_div: divide a window sum by its constant length
// Two stages: reciprocal multiply, then shift, sign restore and masking.
// ----------------------------------------------------------------------------
module mwta_div
  import mwta_pkg::*;
(
  input  logic                          clk_i,
  input  mwta_adv_t                     adv_i,
  input  logic                          neg_i,
  input  logic                          ok_i,
  input  logic [MAG_W-1:0]              mag_i,
  input  logic [RECIP_W-1:0]            recip_i,
  input  logic [SHIFT_W-1:0]            shift_i,
  output logic signed [SAMPLE_BITS-1:0] avg_o,
  output logic                          ok_o
);

  logic [PROD_W-1:0]             prod_q;
  logic                          neg_q;
  logic                          okm_q;
  logic [PROD_W-1:0]             quot;
  logic [SAMPLE_BITS-1:0]        qmag;
  logic signed [SAMPLE_BITS-1:0] avg_d;
  logic signed [SAMPLE_BITS-1:0] avg_q;
  logic                          ok_q;

  // Multiply stage
  always_ff @(posedge clk_i) begin
    if (adv_i.mul) begin
      prod_q <= PROD_W'(mag_i) * PROD_W'(recip_i);
      neg_q  <= neg_i;
      okm_q  <= ok_i;
    end
  end

  // Truncated quotient magnitude, then sign back on; empty window reads zero
  always_comb begin
    quot  = prod_q >> shift_i;
    qmag  = quot[SAMPLE_BITS-1:0];
    if (!okm_q) begin
      avg_d = '0;
    end else if (neg_q) begin
      avg_d = -$signed(qmag);
    end else begin
      avg_d = $signed(qmag);
    end
  end

  // Result stage
  always_ff @(posedge clk_i) begin
    if (adv_i.fin) begin
      avg_q <= avg_d;
      ok_q  <= okm_q;
    end
  end

  assign avg_o = avg_q;
  assign ok_o  = ok_q;

endmodule

@@ hdl/multi_window_trailing_average_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_window_trailing_average_top: six trailing averages per sample
// Gives the means of the 3, 5, 10, 30, 60 and 120 samples before each one.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_ready_o carries one word per sample:
//   strength_i (signed, 8 fraction bits) and start_series_i, which clears
//   the history before that sample. Output channel out_valid_o /
//   out_ready_i carries one result word per sample: avg_3_o .. avg_120_o
//   and valid_mask_o, where bit k is set once window k has enough samples.
//   A window without enough history reads as zero.
//   Words pass the stage-1, product and result registers before out_valid_o.
//   One word is taken every cycle while in_ready_o is high; the running
//   sums update in the accept cycle (one add and one subtract per window),
//   and each constant divide takes a multiply stage and a finish stage.
//   Reset clears the fill count, the running sums and all stage valids;
//   the history line itself needs no clearing since taps past the fill
//   count are never read.
//   When the receiver stalls, the three stages fill up and in_ready_o
//   drops only once every stage holds a word.
// ----------------------------------------------------------------------------
module multi_window_trailing_average_top
  import mwta_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] strength_i,
  input  logic                          start_series_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] avg_3_o,
  output logic signed [SAMPLE_BITS-1:0] avg_5_o,
  output logic signed [SAMPLE_BITS-1:0] avg_10_o,
  output logic signed [SAMPLE_BITS-1:0] avg_30_o,
  output logic signed [SAMPLE_BITS-1:0] avg_60_o,
  output logic signed [SAMPLE_BITS-1:0] avg_120_o,
  output logic [WIN_COUNT-1:0]          valid_mask_o
);

  logic                          accept;
  logic                          en1, en2, en3;
  logic                          v1_q, v2_q, v3_q;
  mwta_adv_t                     adv;
  logic [SEEN_W-1:0]             seen_q, seen_d;
  logic signed [SAMPLE_BITS-1:0] hist [LONGEST_WINDOW];
  logic                          neg1_q [WIN_COUNT];
  logic                          ok1_q  [WIN_COUNT];
  logic [MAG_W-1:0]              mag1_q [WIN_COUNT];
  logic signed [SAMPLE_BITS-1:0] avg    [WIN_COUNT];
  logic [WIN_COUNT-1:0]          ok_out;

  // Pipeline flow: a stage moves when it is empty or its successor moves
  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign accept     = in_valid_i && in_ready_o;
  assign adv.mul    = en2;
  assign adv.fin    = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // History line: cell 0 takes the new sample, each cell its neighbor's
  genvar gi;
  generate
    for (gi = 0; gi < LONGEST_WINDOW; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        mwta_cell u_cell (
          .clk_i   (clk_i),
          .shift_i (accept),
          .d_i     (strength_i),
          .q_o     (hist[gi])
        );
      end else begin : g_body
        mwta_cell u_cell (
          .clk_i   (clk_i),
          .shift_i (accept),
          .d_i     (hist[gi-1]),
          .q_o     (hist[gi])
        );
      end
    end
  endgenerate

  // Saturating fill count; a start word makes its sample the first one
  always_comb begin
    if (start_series_i) begin
      seen_d = SEEN_W'(1);
    end else if (seen_q < SEEN_W'(LONGEST_WINDOW)) begin
      seen_d = seen_q + SEEN_W'(1);
    end else begin
      seen_d = seen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (accept) begin
      seen_q <= seen_d;
    end
  end

  // Per window: running sum, sign/magnitude split and constant divider
  genvar gk;
  generate
    for (gk = 0; gk < WIN_COUNT; gk++) begin : g_win
      logic             ok0;
      logic             neg0;
      logic [MAG_W-1:0] mag0;

      if (WIN_LEN[gk] <= LONGEST_WINDOW) begin : g_live
        logic signed [SUM_W-1:0] sum_q, sum_d, sum_eff, drop;
        logic                    full;

        assign full    = (seen_q >= SEEN_W'(WIN_LEN[gk]));
        assign drop    = full ? SUM_W'(hist[WIN_LEN[gk]-1]) : '0;
        assign sum_eff = start_series_i ? '0 : sum_q;
        assign sum_d   = start_series_i ? SUM_W'(strength_i)
                                        : sum_q + SUM_W'(strength_i) - drop;
        assign ok0     = full && !start_series_i;
        assign neg0    = sum_eff[SUM_W-1];
        assign mag0    = neg0 ? MAG_W'(-sum_eff) : MAG_W'(sum_eff);

        always_ff @(posedge clk_i or negedge rst_ni) begin
          if (!rst_ni) begin
            sum_q <= '0;
          end else if (accept) begin
            sum_q <= sum_d;
          end
        end
      end else begin : g_dead
        // Longer than the history line: never valid
        assign ok0  = 1'b0;
        assign neg0 = 1'b0;
        assign mag0 = '0;
      end

      // Stage 1 payload
      always_ff @(posedge clk_i) begin
        if (accept) begin
          neg1_q[gk] <= neg0;
          ok1_q[gk]  <= ok0;
          mag1_q[gk] <= mag0;
        end
      end

      mwta_div u_div (
        .clk_i   (clk_i),
        .adv_i   (adv),
        .neg_i   (neg1_q[gk]),
        .ok_i    (ok1_q[gk]),
        .mag_i   (mag1_q[gk]),
        .recip_i (RECIP[gk]),
        .shift_i (SHIFT_W'(MAG_W + DIV_SHIFT[gk])),
        .avg_o   (avg[gk]),
        .ok_o    (ok_out[gk])
      );
    end
  endgenerate

  assign out_valid_o  = v3_q;
  assign avg_3_o      = avg[0];
  assign avg_5_o      = avg[1];
  assign avg_10_o     = avg[2];
  assign avg_30_o     = avg[3];
  assign avg_60_o     = avg[4];
  assign avg_120_o    = avg[5];
  assign valid_mask_o = ok_out;

  // Assertions
  a_mask_nested: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!valid_mask_o[5] || valid_mask_o[4]) &&
                     (!valid_mask_o[4] || valid_mask_o[3]) &&
                     (!valid_mask_o[3] || valid_mask_o[2]) &&
                     (!valid_mask_o[2] || valid_mask_o[1]) &&
                     (!valid_mask_o[1] || valid_mask_o[0])))
    else $error("valid mask not nested by window length");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_mask_o[0]) |-> (avg_3_o == '0))
    else $error("average of a short window is not zero");

  a_start_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && start_series_i) |=> (seen_q == SEEN_W'(1)))
    else $error("fill count not restarted by start word");

  a_seen_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SEEN_W'(LONGEST_WINDOW))
    else $error("fill count beyond history depth");

  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while all stages are full and stalled");

endmodule
